/* design/stack_map_v3_stream_parser_defines.svh */
// Assertion macros shared by the stack map parser.
`ifndef STACK_MAP_V3_STREAM_PARSER_DEFINES_SVH
`define STACK_MAP_V3_STREAM_PARSER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SMP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* design/smp_pkg.sv */
// Types and constants shared by the stack map parser modules.
`default_nettype none
package smp_pkg;
   localparam logic [7:0] VERSION = 8'd3;

   typedef enum logic [3:0] {
      PH_HEADER, PH_FUNC, PH_CONST, PH_REC_HEAD, PH_LOC, PH_LOC_PAD,
      PH_LIVE_HEAD, PH_LIVE, PH_TAIL_PAD, PH_DONE, PH_ERROR, PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CONST = 2'd0, KIND_HEAD = 2'd1, KIND_LOC = 2'd2, KIND_STATUS = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_SHORT = 3'd1, ST_VERSION = 3'd2, ST_TRUNC = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   // Controller states for the function skip walk.
   typedef enum logic [1:0] {C_IDLE, C_READ, C_CHECK} cstate_type;

   // Result item as it travels to the output register.
   typedef struct packed {
      logic [1:0]  item_kind;
      logic [63:0] wide_value;
      logic [63:0] patch_point_id;
      logic [15:0] location_count;
      logic [7:0]  location_kind;
      logic [15:0] location_size;
      logic [15:0] location_register;
      logic [31:0] location_offset;
      logic [2:0]  status;
      logic        run_last;
   } result_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic        rec_exhausted; // current function has no records left
      logic        func_in_range; // function_index below total
   } dp_status_type;
endpackage
`default_nettype wire

/* design/stack_map_v3_stream_parser.sv */
// Top level of the stack map v3 stream parser.
// The first result that a request byte completes is registered and appears on rsp_ in the cycle after that byte.
// Input takes one byte per cycle while the output register is free; each record start
// stalls input for the table read and check, and again for every exhausted function the walk steps past.
// A byte causing two results blocks input while the second drains.
// Reset is synchronous, active high, and returns the parser to the header phase.
`default_nettype none
`include "stack_map_v3_stream_parser_defines.svh"
module stack_map_v3_stream_parser #(
   parameter int MAX_FUNCTIONS = 256
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,  // data_byte
   input  wire logic          req_tlast,  // last_byte
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [223:0]       rsp_tdata,  // wide_value, patch_point_id, location_count,
                                          // location_kind, location_size,
                                          // location_register, location_offset, status
   output logic [1:0]         rsp_tuser,  // item_kind
   output logic               rsp_tlast   // run_last
);
   import smp_pkg::*;

   logic          byte_en, skip_req, skip_busy, skip_step, skip_done, rd_ready;
   dp_status_type dp_status;
   logic          res_valid, res_two;
   result_type    res0, res1;
   result_type    out_ff, hold_ff;
   logic          out_v_ff, hold_v_ff;
   logic          out_free;

   assign out_free   = !out_v_ff || rsp_tready;
   assign req_tready = out_free && !hold_v_ff && !skip_busy;
   assign byte_en    = req_tvalid && req_tready;

   smp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .skip_req(skip_req), .dp_status(dp_status),
      .rd_ready(rd_ready), .skip_busy(skip_busy), .skip_step(skip_step),
      .skip_done(skip_done));

   smp_dp #(.MAX_FUNCTIONS(MAX_FUNCTIONS)) u_dp (
      .clock(clock), .reset(reset), .byte_en(byte_en), .data_byte(req_tdata),
      .last_byte(req_tlast), .skip_step(skip_step), .skip_done(skip_done),
      .skip_req(skip_req), .rd_ready(rd_ready), .dp_status(dp_status),
      .res_valid(res_valid), .res0(res0), .res_two(res_two), .res1(res1));

   // Output register with a second slot for a two-result request.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0; hold_v_ff <= 1'b0;
      end else if (out_free) begin
         if (hold_v_ff) begin
            out_v_ff <= 1'b1; out_ff <= hold_ff; hold_v_ff <= 1'b0;
         end else begin
            out_v_ff <= res_valid; out_ff <= res0;
            hold_v_ff <= res_two; hold_ff <= res1;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_ff.item_kind;
   assign rsp_tlast  = out_ff.run_last;
   assign rsp_tdata  = {5'd0, out_ff.status, out_ff.location_offset,
                        out_ff.location_register, out_ff.location_size,
                        out_ff.location_kind, out_ff.location_count,
                        out_ff.patch_point_id, out_ff.wide_value};

   // No byte is taken while the function walk runs.
   `SMP_ASSERT_IMPL(a_no_byte_in_walk, clock, reset, skip_busy, !byte_en)
   // A waiting second result always goes out next.
   `SMP_ASSERT_NEXT(a_hold_drains, clock, reset, hold_v_ff && out_free, out_v_ff)
   // A skip step only happens inside the walk.
   `SMP_ASSERT_IMPL(a_step_in_walk, clock, reset, skip_step, skip_busy)
endmodule
`default_nettype wire

/* design/smp_ram.sv */
// Generic RAM with one write port and one registered read port.
`default_nettype none
module smp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* design/smp_ctrl.sv */
// Controller for the stack map parser: runs the function skip walk; its busy flag holds off byte acceptance.
`default_nettype none
module smp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  skip_req,
   input  wire smp_pkg::dp_status_type dp_status,
   input  wire logic                  rd_ready,
   output logic                       skip_busy,
   output logic                       skip_step,
   output logic                       skip_done
);
   import smp_pkg::*;

   cstate_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Walk: wait for the table read, then step past an exhausted function in range, or else finish the walk.
   always_comb begin
      state_in  = state_ff;
      skip_step = 1'b0;
      skip_done = 1'b0;
      skip_busy = (state_ff != C_IDLE);
      unique case (state_ff)
         C_IDLE: begin
            if (skip_req) state_in = C_READ;
         end
         C_READ: begin
            if (rd_ready) state_in = C_CHECK;
         end
         C_CHECK: begin
            if (dp_status.func_in_range && dp_status.rec_exhausted) begin
               skip_step = 1'b1;
               state_in  = C_READ;
            end else begin
               skip_done = 1'b1;
               state_in  = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* design/smp_dp.sv */
// Datapath for the stack map parser: byte assembly, counters, function table.
`default_nettype none
module smp_dp #(
   parameter int MAX_FUNCTIONS = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   byte_en,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   last_byte,
   input  wire logic                   skip_step,
   input  wire logic                   skip_done,
   output logic                        skip_req,
   output logic                        rd_ready,
   output smp_pkg::dp_status_type      dp_status,
   output logic                        res_valid,
   output smp_pkg::result_type         res0,
   output logic                        res_two,
   output smp_pkg::result_type         res1
);
   import smp_pkg::*;

   localparam int AW = (MAX_FUNCTIONS > 1) ? $clog2(MAX_FUNCTIONS) : 1;
   localparam int IW = $clog2(MAX_FUNCTIONS + 1);

   phase_type   phase_ff, phase_in;
   logic [2:0]  align_ff, align_in;
   logic [4:0]  ib_ff, ib_in;
   logic [4:0]  seen_ff, seen_in;
   logic [2:0]  err_ff, err_in;
   logic [31:0] ftot_ff, ftot_in, cleft_ff, cleft_in, rleft_ff, rleft_in;
   logic [15:0] lleft_ff, lleft_in, vleft_ff, vleft_in;
   logic [IW-1:0] fidx_ff, fidx_in;
   logic [63:0] rif_ff, rif_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] base_ff, base_in;
   logic [63:0] pid_ff, pid_in;
   logic [31:0] off_ff, off_in;
   logic [15:0] w16_ff, w16_in;
   logic [23:0] lkr_ff, lkr_in;
   logic        owned_ff, owned_in;
   logic        rd_ok_ff;

   logic        wr_en;
   logic [63:0] base_rd, rec_rd;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [63:0] nacc;
   logic [4:0]  nib;
   logic        want_skip;
   logic        in_range;
   result_type  r0, r1;
   logic        v0, v1;
   logic [2:0]  st;
   logic        go_rec;

   assign rd_addr = fidx_ff[AW-1:0];
   assign wr_addr = fidx_ff[AW-1:0];
   assign in_range = ({{(32-IW){1'b0}}, fidx_ff} < ftot_ff);

   smp_ram #(.WIDTH(64), .DEPTH(MAX_FUNCTIONS)) u_base (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(base_ff),
      .rd_addr(rd_addr), .rd_data(base_rd));
   smp_ram #(.WIDTH(64), .DEPTH(MAX_FUNCTIONS)) u_recs (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(nacc),
      .rd_addr(rd_addr), .rd_data(rec_rd));

   assign dp_status.rec_exhausted = (rif_ff >= rec_rd);
   assign dp_status.func_in_range = in_range;
   assign rd_ready = rd_ok_ff;

   // Little-endian byte assembly into the accumulator, each byte placed by its index.
   always_comb begin
      nib  = ib_ff + 5'd1;
      nacc = acc_ff;
      unique case (ib_ff[2:0])
         3'd0: nacc = {56'd0, data_byte};
         3'd1: nacc[15:8]  = data_byte;
         3'd2: nacc[23:16] = data_byte;
         3'd3: nacc[31:24] = data_byte;
         3'd4: nacc[39:32] = data_byte;
         3'd5: nacc[47:40] = data_byte;
         3'd6: nacc[55:48] = data_byte;
         3'd7: nacc[63:56] = data_byte;
         default: nacc = acc_ff;
      endcase
   end

   // Byte-level parse: next state and emitted results.
   always_comb begin
      phase_in = phase_ff; align_in = align_ff; ib_in = ib_ff;
      seen_in = seen_ff; err_in = err_ff; ftot_in = ftot_ff;
      cleft_in = cleft_ff; rleft_in = rleft_ff; lleft_in = lleft_ff;
      vleft_in = vleft_ff; fidx_in = fidx_ff; rif_in = rif_ff;
      acc_in = acc_ff; base_in = base_ff; pid_in = pid_ff; off_in = off_ff;
      w16_in = w16_ff; lkr_in = lkr_ff; owned_in = owned_ff;
      wr_en = 1'b0; want_skip = 1'b0; go_rec = 1'b0;
      r0 = '0; r1 = '0; v0 = 1'b0; v1 = 1'b0; st = ST_OK;

      if (skip_step) begin
         fidx_in = fidx_ff + 1'b1;
         rif_in  = '0;
      end
      if (skip_done) phase_in = PH_REC_HEAD;

      if (byte_en) begin
         if (seen_ff < 5'd16) seen_in = seen_ff + 5'd1;
         align_in = align_ff + 3'd1;
         acc_in = nacc;
         ib_in = nib;
         case (phase_ff)
            PH_DONE, PH_ERROR, PH_SKIP: ib_in = ib_ff;
            PH_LOC_PAD: begin
               ib_in = ib_ff;
               if (align_in == 3'd0) begin phase_in = PH_LIVE_HEAD; ib_in = '0; end
            end
            PH_TAIL_PAD: begin
               ib_in = ib_ff;
               if (align_in == 3'd0) begin
                  rif_in = rif_ff + 64'd1; rleft_in = rleft_ff - 32'd1; go_rec = 1'b1;
               end
            end
            PH_HEADER: begin
               if (ib_ff == 5'd0 && data_byte != VERSION) begin
                  err_in = ST_VERSION; phase_in = PH_ERROR; ib_in = '0;
               end else if (ib_ff == 5'd7) begin
                  ftot_in = nacc[63:32];
               end else if (ib_ff == 5'd15) begin
                  cleft_in = nacc[31:0];
                  rleft_in = nacc[63:32];
                  fidx_in = '0;
                  ib_in = '0;
                  if (ftot_ff > 32'(MAX_FUNCTIONS)) begin
                     err_in = ST_OVERFLOW; phase_in = PH_ERROR;
                  end else if (ftot_ff != 32'd0) begin
                     phase_in = PH_FUNC;
                  end else if (nacc[31:0] != 32'd0) begin
                     phase_in = PH_CONST;
                  end else begin
                     rif_in = '0; go_rec = 1'b1;
                  end
               end
            end
            PH_FUNC: begin
               if (ib_ff == 5'd7) base_in = nacc;
               if (ib_ff == 5'd23) begin
                  wr_en = 1'b1;
                  ib_in = '0;
                  fidx_in = fidx_ff + 1'b1;
                  if ({{(32-IW){1'b0}}, fidx_in} >= ftot_ff) begin
                     fidx_in = '0; rif_in = '0;
                     if (cleft_ff != 32'd0) phase_in = PH_CONST;
                     else go_rec = 1'b1;
                  end
               end
            end
            PH_CONST: begin
               if (ib_ff == 5'd7) begin
                  v0 = 1'b1; r0.item_kind = KIND_CONST; r0.wide_value = nacc;
                  cleft_in = cleft_ff - 32'd1; ib_in = '0;
                  if (cleft_in == 32'd0) go_rec = 1'b1;
               end
            end
            PH_REC_HEAD: begin
               if (ib_ff == 5'd7) pid_in = nacc;
               if (ib_ff == 5'd11) off_in = nacc[31:0];
               if (ib_ff == 5'd15) begin
                  lleft_in = nacc[63:48];
                  owned_in = in_range;
                  if (in_range) begin
                     v0 = 1'b1; r0.item_kind = KIND_HEAD;
                     r0.wide_value = base_rd + {32'd0, off_ff};
                     r0.patch_point_id = pid_ff;
                     r0.location_count = nacc[63:48];
                  end
                  ib_in = '0;
                  if (nacc[63:48] != 16'd0) phase_in = PH_LOC;
                  else phase_in = (align_in != 3'd0) ? PH_LOC_PAD : PH_LIVE_HEAD;
               end
            end
            PH_LOC: begin
               if (ib_ff == 5'd3) w16_in = nacc[31:16];
               // Kind byte and register number are kept before the offset word.
               if (ib_ff == 5'd5) lkr_in = {nacc[7:0], nacc[47:32]};
               if (ib_ff == 5'd11) begin
                  if (owned_ff) begin
                     v0 = 1'b1; r0.item_kind = KIND_LOC;
                     r0.location_kind = lkr_ff[23:16];
                     r0.location_size = w16_ff;
                     r0.location_register = lkr_ff[15:0];
                     r0.location_offset = nacc[31:0];
                  end
                  lleft_in = lleft_ff - 16'd1; ib_in = '0;
                  if (lleft_in == 16'd0)
                     phase_in = (align_in != 3'd0) ? PH_LOC_PAD : PH_LIVE_HEAD;
               end
            end
            PH_LIVE_HEAD: begin
               if (ib_ff == 5'd3) begin
                  vleft_in = nacc[31:16]; ib_in = '0;
                  if (nacc[31:16] != 16'd0) phase_in = PH_LIVE;
                  else if (align_in != 3'd0) phase_in = PH_TAIL_PAD;
                  else begin
                     rif_in = rif_ff + 64'd1; rleft_in = rleft_ff - 32'd1; go_rec = 1'b1;
                  end
               end
            end
            PH_LIVE: begin
               if (ib_ff == 5'd3) begin
                  vleft_in = vleft_ff - 16'd1; ib_in = '0;
                  if (vleft_in == 16'd0) begin
                     if (align_in != 3'd0) phase_in = PH_TAIL_PAD;
                     else begin
                        rif_in = rif_ff + 64'd1; rleft_in = rleft_ff - 32'd1;
                        go_rec = 1'b1;
                     end
                  end
               end
            end
            default: ib_in = ib_ff;
         endcase
         if (go_rec) begin
            ib_in = '0;
            if (rleft_in == 32'd0) phase_in = PH_DONE;
            else begin phase_in = PH_SKIP; want_skip = 1'b1; end
         end
         if (last_byte) begin
            if (seen_in < 5'd16) st = ST_SHORT;
            else if (err_in != 3'd0) st = err_in;
            else if (phase_in == PH_DONE) st = ST_OK;
            else if (phase_in == PH_SKIP && rleft_in == 32'd0) st = ST_OK;
            else if (phase_in == PH_TAIL_PAD && rleft_in == 32'd1) st = ST_OK;
            else st = ST_TRUNC;
            if (v0) begin v1 = 1'b1; r1.item_kind = KIND_STATUS; r1.status = st; end
            else begin v0 = 1'b1; r0.item_kind = KIND_STATUS; r0.status = st; end
            want_skip = 1'b0;
            phase_in = PH_HEADER; align_in = '0; ib_in = '0; seen_in = '0;
            err_in = '0; ftot_in = '0; cleft_in = '0; rleft_in = '0;
            lleft_in = '0; vleft_in = '0; fidx_in = '0; rif_in = '0;
            pid_in = '0; off_in = '0; owned_in = 1'b0;
         end
      end
      if (v1) r1.run_last = 1'b1;
      else r0.run_last = 1'b1;
   end

   assign skip_req  = want_skip;
   assign res_valid = v0;
   assign res0      = r0;
   assign res_two   = v1;
   assign res1      = r1;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; align_ff <= '0; ib_ff <= '0; seen_ff <= '0;
         err_ff <= '0; ftot_ff <= '0; cleft_ff <= '0; rleft_ff <= '0;
         lleft_ff <= '0; vleft_ff <= '0; fidx_ff <= '0; rif_ff <= '0;
         owned_ff <= 1'b0; rd_ok_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; align_ff <= align_in; ib_ff <= ib_in;
         seen_ff <= seen_in; err_ff <= err_in; ftot_ff <= ftot_in;
         cleft_ff <= cleft_in; rleft_ff <= rleft_in; lleft_ff <= lleft_in;
         vleft_ff <= vleft_in; fidx_ff <= fidx_in; rif_ff <= rif_in;
         owned_ff <= owned_in;
         rd_ok_ff <= !(skip_step || want_skip);
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in; base_ff <= base_in; pid_ff <= pid_in;
      off_ff <= off_in; w16_ff <= w16_in; lkr_ff <= lkr_in;
   end
endmodule
`default_nettype wire

/* sim/tb_stack_map_v3_stream_parser.sv */
// Self-checking testbench for the stack map v3 stream parser: random and directed sections.
`default_nettype none
module tb_stack_map_v3_stream_parser;
   import smp_pkg::*;

   localparam int TABLE_DEPTH = 256;
   localparam int STIM_BYTES = 1900;
   localparam int CYCLE_LIMIT = 900000;
   localparam int DRAIN_CYCLES = 12;

   // Stack map parser model with a queue of the result items it expects.
   class map_scoreboard;
      phase_type   phase;
      bit [2:0]    align;
      int unsigned nbytes;
      bit [7:0]    field_bytes[24];
      int unsigned seen;
      bit [2:0]    err_code;
      bit [31:0]   fn_total, const_left, rec_left, fn_idx, cur_offset;
      bit [15:0]   loc_left, live_left;
      bit [63:0]   rec_in_fn, cur_patch;
      bit [63:0]   fn_base[TABLE_DEPTH];
      bit [63:0]   fn_recs[TABLE_DEPTH];
      bit          owned;
      result_type  pending[$];
      int          errors;

      function new();
         errors = 0;
         clear_parser();
      endfunction

      function void clear_parser();
         phase = PH_HEADER;
         align = 0;
         nbytes = 0;
         seen = 0;
         err_code = 0;
         fn_total = 0;
         const_left = 0;
         rec_left = 0;
         fn_idx = 0;
         cur_offset = 0;
         loc_left = 0;
         live_left = 0;
         rec_in_fn = 0;
         cur_patch = 0;
         owned = 0;
         foreach (field_bytes[i]) field_bytes[i] = 0;
      endfunction

      function bit [63:0] le_field(int at, int len);
         bit [63:0] v;
         v = 0;
         for (int i = 0; i < len; i++) v |= 64'(field_bytes[at + i]) << (8 * i);
         return v;
      endfunction

      function void push_item(kind_type kind, bit [63:0] wide, bit [63:0] pid,
                              bit [15:0] lc, bit [7:0] lk, bit [15:0] ls,
                              bit [15:0] lr, bit [31:0] lo, status_type st);
         result_type r;
         r = '0;
         r.item_kind = kind;
         r.wide_value = wide;
         r.patch_point_id = pid;
         r.location_count = lc;
         r.location_kind = lk;
         r.location_size = ls;
         r.location_register = lr;
         r.location_offset = lo;
         r.status = st;
         pending.push_back(r);
      endfunction

      function void set_phase(phase_type p);
         phase = p;
         nbytes = 0;
      endfunction

      // Walk past functions whose records are used up before the next record.
      function void enter_records();
         if (rec_left == 0) begin
            set_phase(PH_DONE);
            return;
         end
         while (fn_idx < fn_total && fn_idx < TABLE_DEPTH && rec_in_fn >= fn_recs[fn_idx]) begin
            rec_in_fn = 0;
            fn_idx++;
         end
         set_phase(PH_REC_HEAD);
      endfunction

      function void enter_constants();
         if (const_left != 0) set_phase(PH_CONST);
         else enter_records();
      endfunction

      function void finish_record();
         rec_in_fn++;
         rec_left--;
         enter_records();
      endfunction

      function void after_live();
         if (align != 0) set_phase(PH_TAIL_PAD);
         else finish_record();
      endfunction

      function void after_locs();
         set_phase(align != 0 ? PH_LOC_PAD : PH_LIVE_HEAD);
      endfunction

      function void consume(bit [7:0] b);
         if (phase == PH_DONE || phase == PH_ERROR) return;
         if (phase == PH_LOC_PAD) begin
            if (align == 0) set_phase(PH_LIVE_HEAD);
            return;
         end
         if (phase == PH_TAIL_PAD) begin
            if (align == 0) finish_record();
            return;
         end
         if (nbytes < 24) field_bytes[nbytes] = b;
         nbytes++;
         case (phase)
            PH_HEADER: begin
               if (nbytes == 1 && b != VERSION) begin
                  err_code = ST_VERSION;
                  set_phase(PH_ERROR);
               end else if (nbytes == 16) begin
                  fn_total = 32'(le_field(4, 4));
                  const_left = 32'(le_field(8, 4));
                  rec_left = 32'(le_field(12, 4));
                  fn_idx = 0;
                  if (fn_total > TABLE_DEPTH) begin
                     err_code = ST_OVERFLOW;
                     set_phase(PH_ERROR);
                  end else if (fn_total != 0) begin
                     set_phase(PH_FUNC);
                  end else begin
                     enter_constants();
                  end
               end
            end
            PH_FUNC: begin
               if (nbytes == 24) begin
                  if (fn_idx < TABLE_DEPTH) begin
                     fn_base[fn_idx] = le_field(0, 8);
                     fn_recs[fn_idx] = le_field(16, 8);
                  end
                  fn_idx++;
                  nbytes = 0;
                  if (fn_idx >= fn_total) begin
                     fn_idx = 0;
                     rec_in_fn = 0;
                     enter_constants();
                  end
               end
            end
            PH_CONST: begin
               if (nbytes == 8) begin
                  push_item(KIND_CONST, le_field(0, 8), 0, 0, 0, 0, 0, 0, ST_OK);
                  const_left--;
                  nbytes = 0;
                  if (const_left == 0) enter_records();
               end
            end
            PH_REC_HEAD: begin
               if (nbytes == 16) begin
                  cur_patch = le_field(0, 8);
                  cur_offset = 32'(le_field(8, 4));
                  loc_left = 16'(le_field(14, 2));
                  owned = fn_idx < fn_total && fn_idx < TABLE_DEPTH;
                  if (owned)
                     push_item(KIND_HEAD, fn_base[fn_idx] + 64'(cur_offset), cur_patch,
                               loc_left, 0, 0, 0, 0, ST_OK);
                  if (loc_left != 0) set_phase(PH_LOC);
                  else after_locs();
               end
            end
            PH_LOC: begin
               if (nbytes == 12) begin
                  if (owned)
                     push_item(KIND_LOC, 0, 0, 0, field_bytes[0], 16'(le_field(2, 2)),
                               16'(le_field(4, 2)), 32'(le_field(8, 4)), ST_OK);
                  loc_left--;
                  nbytes = 0;
                  if (loc_left == 0) after_locs();
               end
            end
            PH_LIVE_HEAD: begin
               if (nbytes == 4) begin
                  live_left = 16'(le_field(2, 2));
                  if (live_left != 0) set_phase(PH_LIVE);
                  else after_live();
               end
            end
            PH_LIVE: begin
               if (nbytes == 4) begin
                  live_left--;
                  nbytes = 0;
                  if (live_left == 0) after_live();
               end
            end
            default: ;
         endcase
      endfunction

      // Note one accepted request byte and queue the results it causes.
      function void note_request(bit [7:0] b, bit last);
         int before_n;
         status_type st;
         before_n = pending.size();
         if (seen < 16) seen++;
         align = align + 3'd1;
         consume(b);
         if (last) begin
            if (seen < 16) st = ST_SHORT;
            else if (err_code != 0) st = status_type'(err_code);
            else if (phase == PH_DONE || (phase == PH_TAIL_PAD && rec_left == 1)) st = ST_OK;
            else st = ST_TRUNC;
            push_item(KIND_STATUS, 0, 0, 0, 0, 0, 0, 0, st);
            clear_parser();
         end
         if (pending.size() > before_n) pending[pending.size() - 1].run_last = 1'b1;
      endfunction

      // Compare one accepted result against the oldest expected item.
      function void check_result(logic [223:0] d, logic [1:0] u, logic l);
         result_type got, want;
         got.item_kind = u;
         got.wide_value = d[63:0];
         got.patch_point_id = d[127:64];
         got.location_count = d[143:128];
         got.location_kind = d[151:144];
         got.location_size = d[167:152];
         got.location_register = d[183:168];
         got.location_offset = d[215:184];
         got.status = d[218:216];
         got.run_last = l;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result: %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("result mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [7:0]    req_tdata = 0;
   logic          req_tlast = 0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [223:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          rsp_tlast;

   map_scoreboard sb = new();
   bit [7:0]      section[$];
   int            sent_bytes = 0;
   bit            calm = 0;
   int unsigned   cycles = 0;

   stack_map_v3_stream_parser u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #2 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Response side: random back-pressure plus one long hold-off.
   always @(posedge clock) begin
      int stall;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if (cycles == 3000) stall = 400;
         else if (stall == 0) stall = pick_gap();
         else stall--;
         rsp_tready <= (stall == 0);
      end
   end

   function void put_le(bit [63:0] v, int n);
      for (int i = 0; i < n; i++) section.push_back(v[8 * i +: 8]);
   endfunction

   function bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function void pad_to_eight();
      while (section.size() % 8 != 0) section.push_back($urandom);
   endfunction

   // Stack map, well-formed unless cut short; extreme selects all-ones for most fields.
   function void build_map(bit extreme);
      int nf, nc, nr, nloc, nlive;
      section.delete();
      nf = extreme ? 1 : $urandom_range(0, 4);
      nc = extreme ? 1 : $urandom_range(0, 3);
      nr = extreme ? 2 : $urandom_range(0, 5);
      put_le(VERSION, 1);
      put_le(extreme ? '1 : rand64(), 3);
      put_le(nf, 4);
      put_le(nc, 4);
      put_le(nr, 4);
      for (int f = 0; f < nf; f++) begin
         put_le(extreme ? '1 : rand64(), 8);
         put_le(rand64(), 8);
         if (extreme) put_le(1, 8);
         else if ($urandom_range(0, 7) == 0) put_le(rand64(), 8);
         else put_le($urandom_range(0, 3), 8);
      end
      for (int c = 0; c < nc; c++) put_le(extreme ? '1 : rand64(), 8);
      for (int r = 0; r < nr; r++) begin
         nloc = extreme ? 1 : $urandom_range(0, 3);
         put_le(extreme ? '1 : rand64(), 8);
         put_le(extreme ? '1 : rand64(), 6);
         put_le(nloc, 2);
         for (int k = 0; k < nloc; k++) begin
            put_le(extreme ? '1 : rand64(), 8);
            put_le(extreme ? 64'h8000_0000 : rand64(), 4);
         end
         pad_to_eight();
         nlive = extreme ? 1 : $urandom_range(0, 2);
         put_le(rand64(), 2);
         put_le(nlive, 2);
         for (int k = 0; k < nlive; k++) put_le(rand64(), 4);
         pad_to_eight();
      end
      if (!extreme) begin
         put_le(rand64(), $urandom_range(0, 3));
         // Cut some sections short to exercise truncation.
         if ($urandom_range(0, 4) == 0 && section.size() > 1)
            section = section[0:$urandom_range(0, section.size() - 2)];
      end
   endfunction

   function void build_header(bit [7:0] ver, bit [31:0] nf, int extra);
      section.delete();
      put_le(ver, 1);
      put_le(rand64(), 3);
      put_le(nf, 4);
      put_le(rand64(), 8);
      for (int i = 0; i < extra; i++) section.push_back($urandom);
   endfunction

   task automatic send_byte(bit [7:0] b, bit last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_request(b, last);
      sent_bytes++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_section();
      foreach (section[i]) send_byte(section[i], i == section.size() - 1);
   endtask

   initial begin
      int sel;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: short section, header with no functions, bad version, table overflow, extremes.
      section = '{8'h03};
      send_section();
      build_header(VERSION, 0, 0);
      send_section();
      build_header(8'hFF, 0, 1);
      send_section();
      build_header(VERSION, 32'hFFFF_FFFF, 2);
      send_section();
      build_map(1'b1);
      send_section();

      // Random part: mostly well-formed maps, some noise and broken headers.
      while (sent_bytes < STIM_BYTES) begin
         calm = ($urandom_range(0, 3) == 0);
         sel = $urandom_range(0, 19);
         if (sel < 15) begin
            build_map(1'b0);
         end else if (sel < 17) begin
            section.delete();
            repeat ($urandom_range(1, 40)) section.push_back($urandom);
            if ($urandom_range(0, 1)) section[0] = VERSION;
         end else if (sel < 19) begin
            build_header(VERSION, $urandom_range(0, 1) ? 32'd257 : $urandom | 32'h100,
                         $urandom_range(0, 5));
         end else begin
            build_header(VERSION, 0, 0);
            section = section[0:$urandom_range(0, 14)];
         end
         send_section();
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire

/* sim.f */
+incdir+design
design/smp_pkg.sv
design/smp_ram.sv
design/smp_ctrl.sv
design/smp_dp.sv
design/stack_map_v3_stream_parser.sv
sim/tb_stack_map_v3_stream_parser.sv
